>>> rtl/trht_pkg.sv
// trht_pkg: shared types and constants for the touch region hit table
// request and result item layouts, table entry layout, command and register codes
// no dependencies
package trht_pkg;

    localparam int COORD_W   = 16;
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 5;
    localparam int MARGIN_W  = 8;
    localparam int CFG_IDX_W = 8;
    // signed bound width: sum of two coordinates plus a margin, and a sign bit
    localparam int BND_W     = COORD_W + 3;

    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_HIT     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y = 8'd1;

    localparam logic [MARGIN_W-1:0] MARGIN_X_RST = 8'd30;
    localparam logic [MARGIN_W-1:0] MARGIN_Y_RST = 8'd20;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic               start_disabled;
        logic               large_touch;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
    } request_t;

    typedef struct packed {
        logic              success;
        logic [SLOT_W-1:0] slot_out;
    } result_t;

    // geometry and the marks that live in memory; the used mark is kept in flops
    typedef struct packed {
        logic               large_touch;
        logic               disabled;
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic used;
    } issue_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } match_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_HIT,
        ST_RMW_RD,
        ST_RMW_WR
    } state_t;

endpackage

>>> rtl/trht_mem.sv
// trht_mem: entry memory, one write port and one registered read port
// uses trht_pkg for the entry layout
module trht_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  trht_pkg::entry_t  wr_data,
    input  logic [AW-1:0]     rd_addr,
    output trht_pkg::entry_t  rd_data
);
    import trht_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/trht_match.sv
// trht_match: two-stage point-in-rectangle check behind the memory read port
// stage one builds signed bounds from read data, stage two compares; uses trht_pkg
module trht_match #(
    parameter int IDX_W = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  trht_pkg::issue_t                  issue,
    input  logic [IDX_W-1:0]                  issue_tag,
    input  logic                              flush,
    input  trht_pkg::entry_t                  rd_data,
    input  logic [trht_pkg::COORD_W-1:0]      point_x,
    input  logic [trht_pkg::COORD_W-1:0]      point_y,
    input  logic [trht_pkg::MARGIN_W-1:0]     margin_x,
    input  logic [trht_pkg::MARGIN_W-1:0]     margin_y,
    output trht_pkg::match_t                  match,
    output logic [IDX_W-1:0]                  match_tag
);
    import trht_pkg::*;

    logic                    s1_valid_reg;
    logic                    s1_used_reg;
    logic [IDX_W-1:0]        s1_tag_reg;

    logic                    s2_valid_reg;
    logic                    s2_cand_reg;
    logic [IDX_W-1:0]        s2_tag_reg;
    logic signed [BND_W-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;

    logic [MARGIN_W-1:0]     mx_eff, my_eff;
    logic signed [BND_W-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;
    logic signed [BND_W-1:0] px_ext, py_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue.valid && !flush;
            s2_valid_reg <= s1_valid_reg && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_used_reg <= issue.used;
        s1_tag_reg  <= issue_tag;
        s2_cand_reg <= s1_used_reg && !rd_data.disabled;
        s2_tag_reg  <= s1_tag_reg;
        lo_x_reg    <= lo_x_next;
        hi_x_reg    <= hi_x_next;
        lo_y_reg    <= lo_y_next;
        hi_y_reg    <= hi_y_next;
    end

    // large entries grow by the margin on every side
    always_comb
    begin
        mx_eff    = rd_data.large_touch ? margin_x : '0;
        my_eff    = rd_data.large_touch ? margin_y : '0;
        lo_x_next = BND_W'(rd_data.left) - BND_W'(mx_eff);
        hi_x_next = BND_W'(rd_data.left) + BND_W'(rd_data.width) + BND_W'(mx_eff);
        lo_y_next = BND_W'(rd_data.top) - BND_W'(my_eff);
        hi_y_next = BND_W'(rd_data.top) + BND_W'(rd_data.height) + BND_W'(my_eff);
    end

    assign px_ext = BND_W'(point_x);
    assign py_ext = BND_W'(point_y);

    assign match.valid = s2_valid_reg;
    assign match.hit   = s2_cand_reg
                      && (px_ext >= lo_x_reg) && (px_ext <= hi_x_reg)
                      && (py_ext >= lo_y_reg) && (py_ext <= hi_y_reg);
    assign match_tag   = s2_tag_reg;

endmodule

>>> rtl/touch_region_hit_table.sv
// touch_region_hit_table: delete, clear all, unknown commands and enable or disable of an
// unused slot report in the cycle after they are accepted; enable and disable of a used
// slot do a read-modify-write of one entry; an add scans for a free slot (one used flag
// checked per cycle) and fails on a full table; a hit test reads one entry per cycle
// through a read/bound/compare pipe. one item at a time; the next may start as its result
// is shown. reset empties the table and restores margins.
module touch_region_hit_table #(
    parameter int SLOTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  trht_pkg::request_t                  request,
    output logic                                done,
    output trht_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trht_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trht_pkg::MARGIN_W-1:0]       cfg_data
);
    import trht_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;
    request_t            req_reg;
    logic [MARGIN_W-1:0] margin_x_reg, margin_y_reg;

    logic                accept;
    logic [IDX_W-1:0]    acc_idx, req_idx, cnt_idx;
    logic                tgt_used;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    entry_t              mem_wdata, mem_rdata, new_entry;

    issue_t              issue;
    logic                flush;
    match_t              hit_res;
    logic [IDX_W-1:0]    hit_tag;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign acc_idx  = IDX_W'(request.slot);
    assign req_idx  = IDX_W'(req_reg.slot);
    assign cnt_idx  = cnt_reg[IDX_W-1:0];
    assign tgt_used = (32'(request.slot) < 32'(SLOTS)) && used_reg[acc_idx];

    always_comb
    begin
        new_entry.large_touch = req_reg.large_touch;
        new_entry.disabled    = req_reg.start_disabled;
        new_entry.height      = req_reg.rect_height;
        new_entry.width       = req_reg.rect_width;
        new_entry.top         = req_reg.rect_top;
        new_entry.left        = req_reg.rect_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            used_reg   <= used_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_x_reg <= MARGIN_X_RST;
            margin_y_reg <= MARGIN_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MARGIN_X)
            begin
                margin_x_reg <= cfg_data;
            end
            if (cfg_index == CFG_MARGIN_Y)
            begin
                margin_y_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        used_next   = used_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = cnt_idx;
        mem_wdata   = new_entry;
        mem_raddr   = '0;
        issue       = '0;
        flush       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    case (request.cmd)
                        CMD_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        CMD_HIT:
                        begin
                            state_next = ST_HIT;
                        end
                        CMD_DELETE:
                        begin
                            done_next            = 1'b1;
                            result_next.success  = tgt_used;
                            result_next.slot_out = '0;
                            if (tgt_used)
                            begin
                                used_next[acc_idx] = 1'b0;
                            end
                        end
                        CMD_ENABLE, CMD_DISABLE:
                        begin
                            if (tgt_used)
                            begin
                                state_next = ST_RMW_RD;
                            end
                            else
                            begin
                                done_next            = 1'b1;
                                result_next.success  = 1'b0;
                                result_next.slot_out = '0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            // geometry of unused entries never affects a result, so flags suffice
                            used_next            = '0;
                            done_next            = 1'b1;
                            result_next.success  = 1'b1;
                            result_next.slot_out = '0;
                        end
                        default:
                        begin
                            done_next            = 1'b1;
                            result_next.success  = 1'b0;
                            result_next.slot_out = '0;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (!used_reg[cnt_idx])
                begin
                    mem_we               = 1'b1;
                    used_next[cnt_idx]   = 1'b1;
                    done_next            = 1'b1;
                    result_next.success  = 1'b1;
                    result_next.slot_out = SLOT_W'(cnt_idx);
                    state_next           = ST_IDLE;
                end
                else if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    done_next            = 1'b1;
                    result_next.success  = 1'b0;
                    result_next.slot_out = '0;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HIT:
            begin
                if (cnt_reg < CNT_W'(SLOTS))
                begin
                    issue.valid = 1'b1;
                    issue.used  = used_reg[cnt_idx];
                    mem_raddr   = cnt_idx;
                    cnt_next    = cnt_reg + 1'b1;
                end
                // entries leave the pipe in slot order, so the first hit is the lowest
                if (hit_res.valid && hit_res.hit)
                begin
                    done_next            = 1'b1;
                    result_next.success  = 1'b1;
                    result_next.slot_out = SLOT_W'(hit_tag);
                    flush                = 1'b1;
                    state_next           = ST_IDLE;
                end
                else if (hit_res.valid && (hit_tag == IDX_W'(SLOTS - 1)))
                begin
                    done_next            = 1'b1;
                    result_next.success  = 1'b0;
                    result_next.slot_out = '0;
                    flush                = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_RMW_RD:
            begin
                mem_raddr  = req_idx;
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                mem_we               = 1'b1;
                mem_waddr            = req_idx;
                mem_wdata            = mem_rdata;
                mem_wdata.disabled   = (req_reg.cmd == CMD_DISABLE);
                done_next            = 1'b1;
                result_next.success  = 1'b1;
                result_next.slot_out = '0;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    trht_mem #(
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    trht_match #(
        .IDX_W (IDX_W)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_tag (cnt_idx),
        .flush     (flush),
        .rd_data   (mem_rdata),
        .point_x   (req_reg.point_x),
        .point_y   (req_reg.point_y),
        .margin_x  (margin_x_reg),
        .margin_y  (margin_y_reg),
        .match     (hit_res),
        .match_tag (hit_tag)
    );

    // every accepted item either starts work or reports in the next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted item neither started nor reported");

    // the write-back always follows its read
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW_WR) |-> ($past(state_reg) == ST_RMW_RD))
        else $error("entry write-back without a read");

    // no stale scan results left in the pipe once the block is idle
    a_pipe_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hit_res.valid)
        else $error("hit pipeline not empty while idle");

    // the add scan never runs past the table
    a_add_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (cnt_reg < CNT_W'(SLOTS)))
        else $error("add scan beyond table");

endmodule
